/* design/tmls_pkg.sv */
// Shared types and constants for the terminal line scanner.
// No dependencies; used by all design files.
package tmls_pkg;

  localparam int MaxLines = 32;

  localparam logic [2:0] ACT_STATUS = 3'd0;
  localparam logic [2:0] ACT_CTRL   = 3'd1;
  localparam logic [2:0] ACT_WRITE  = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [0:0] REG_MODEM_BASE = 1'b0;
  localparam logic [0:0] REG_LINE_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [24:0] write_data;
    logic        connect_valid;
    logic [4:0]  connect_line;
    logic [31:0] conn_mask;
    logic [31:0] rx_pending_mask;
    logic [31:0] tx_empty_mask;
    logic [7:0]  rx_char;
    logic        rx_break;
    logic        rx_more;
  } in_word_t;

  typedef struct packed {
    logic [23:0] read_data;
    logic        interrupt_active;
    logic [2:0]  pi_channel;
    logic        tx_valid;
    logic [4:0]  tx_line;
    logic [7:0]  tx_char;
    logic        rx_pop;
    logic        hangup_valid;
    logic [4:0]  hangup_line;
    logic        hangup_all;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // apply the action to the state
    logic scan;   // run the scanner and emit the result
  } cmd_t;

endpackage

/* design/tmls_ctrl.sv */
// Controller state machine for the terminal line scanner.
// Depends on tmls_pkg.
module tmls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tmls_pkg::cmd_t cmd
);
  import tmls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state, state_next;
  logic   full, full_next;

  // The output register may be reloaded once it is taken or empty.
  logic out_free;
  assign out_free = !full || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid = full;

  always_comb begin
    state_next = state;
    full_next = full && out_stall;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (out_free) begin
          cmd.scan = 1'b1;
          full_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      full <= 1'b0;
    end else begin
      state <= state_next;
      full <= full_next;
    end
  end
endmodule

/* design/tmls_dp.sv */
// Datapath for the terminal line scanner: line state, attention map, scanner.
// Depends on tmls_pkg.
module tmls_dp #(
  parameter int MAX_LINES = tmls_pkg::MaxLines
) (
  input  logic                clk,
  input  logic                rst,
  input  tmls_pkg::cmd_t      cmd,
  input  tmls_pkg::in_word_t  in_word,
  input  logic                cfg_wen,
  input  logic [0:0]          cfg_index,
  input  logic [5:0]          cfg_data,
  output tmls_pkg::out_word_t out_word
);
  import tmls_pkg::*;

  localparam logic [5:0] MaxL = 6'(MAX_LINES);

  in_word_t    item;
  logic [5:0]  modem_base, line_count;
  logic [63:0] attention_map;
  logic [5:0]  scan_position;
  logic [5:0]  status_bits;
  logic        irq_req;
  logic [MAX_LINES-1:0] transmit_ready, receive_ready, hooked, ringing, answered;
  // Per-step results held between the action and scan cycles.
  logic [23:0] rd;
  logic        txv, pop, hv, ha, do_scan, is_tick;
  logic [4:0]  txl, hl;
  logic [7:0]  txc;
  out_word_t   out_reg;

  assign out_word = out_reg;

  function automatic logic [63:0] bit64(input logic [6:0] n);
    bit64 = (n < 7'd64) ? (64'd1 << n[5:0]) : 64'd0;
  endfunction

  // Combinational action evaluation.
  logic [5:0]  lines, ln, off;
  logic        off_ok;
  logic [MAX_LINES-1:0] m, conn, rxp, txe, mo;
  logic [63:0] am_n;
  logic [5:0]  sb_n, sp_n;
  logic [MAX_LINES-1:0] tr_n, rr_n, oh_n, rg_n, an_n;
  logic [23:0] rd_n;
  logic        txv_n, pop_n, hv_n, ha_n, scan_n, tick_n;
  logic [4:0]  txl_n, hl_n;
  logic [7:0]  txc_n;
  logic [24:0] wd;

  always_comb begin
    wd = item.write_data;
    conn = item.conn_mask[MAX_LINES-1:0];
    rxp = item.rx_pending_mask[MAX_LINES-1:0];
    txe = item.tx_empty_mask[MAX_LINES-1:0];
    lines = (line_count < MaxL) ? line_count : MaxL;
    am_n = attention_map; sb_n = status_bits; sp_n = scan_position;
    tr_n = transmit_ready; rr_n = receive_ready; oh_n = hooked;
    rg_n = ringing; an_n = answered;
    rd_n = '0; txv_n = 1'b0; pop_n = 1'b0; hv_n = 1'b0; ha_n = 1'b0; scan_n = 1'b0;
    tick_n = 1'b0; txl_n = '0; hl_n = '0; txc_n = '0;
    ln = (item.action == ACT_READ) ? scan_position :
         (wd[24] ? wd[23:18] : scan_position);
    off = ln - modem_base;
    off_ok = (ln >= modem_base) && (off < MaxL);
    m = '0;
    mo = '0;
    if (off_ok) mo[off[$clog2(MAX_LINES)-1:0]] = 1'b1;
    if (ln < MaxL) m[ln[$clog2(MAX_LINES)-1:0]] = 1'b1;
    case (item.action)
      ACT_STATUS: begin
        scan_n = (status_bits[4:3] == 2'b00);
      end
      ACT_CTRL: begin
        sb_n[2:0] = wd[2:0];
        if (wd[3]) sp_n = '0;
        if (wd[4]) sb_n[4] = 1'b1;
        if (wd[5]) begin
          sb_n[5:3] = '0; ha_n = 1'b1;
          tr_n = '0; oh_n = '0; rr_n = '0; an_n = '0; rg_n = '0; am_n = '0;
        end
        scan_n = 1'b1;
      end
      ACT_WRITE: begin
        scan_n = 1'b1;
        if (ln >= modem_base) begin
          am_n[ln] = wd[7];
          if (off_ok) begin
            if (!wd[6]) begin
              rr_n = rr_n & ~mo; tr_n = tr_n & ~mo; oh_n = oh_n & ~mo;
              if (|(answered & mo & conn)) begin
                hv_n = 1'b1; hl_n = off[4:0]; an_n = an_n & ~mo;
              end
            end else begin
              oh_n = oh_n | mo;
              if (|(ringing & mo)) begin
                am_n[ln] = 1'b1; rg_n = rg_n & ~mo; an_n = an_n | mo;
              end
            end
          end
        end else if (ln < lines) begin
          if (wd[8]) begin
            tr_n = tr_n & ~m; am_n[ln] = 1'b0;
          end else if (|(conn & m)) begin
            txv_n = 1'b1; txl_n = ln[4:0]; txc_n = wd[7:0];
            tr_n = (|(txe & m)) ? (tr_n | m) : (tr_n & ~m);
            am_n[ln] = 1'b1;
          end
        end
      end
      ACT_READ: begin
        scan_n = 1'b1;
        rd_n = {ln, 18'd0};
        if (ln >= modem_base) begin
          am_n[ln] = 1'b0;
          if (off_ok) begin
            if (|(hooked & mo)) rd_n = rd_n | 24'o500;
            if (|(answered & mo & conn)) rd_n = rd_n | 24'o404;
            if (|(ringing & mo)) rd_n = rd_n | 24'o402;
          end
        end else if (ln < lines) begin
          if (|(rxp & m)) begin
            pop_n = 1'b1;
            rd_n = rd_n | 24'o400 | (item.rx_break ? 24'd0 : {16'd0, item.rx_char});
          end
          if (|(rxp & m) && item.rx_more) begin
            rr_n = rr_n | m; am_n[ln] = 1'b1;
          end else begin
            rr_n = rr_n & ~m; am_n[ln] = 1'b0;
          end
        end
      end
      ACT_TICK: begin
        tick_n = 1'b1;
        if (item.connect_valid && ({1'b0, item.connect_line} < lines)) begin
          rg_n[item.connect_line[$clog2(MAX_LINES)-1:0]] = 1'b1;
          am_n = am_n | bit64({2'b0, item.connect_line} + {1'b0, modem_base});
        end
        for (int i = 0; i < MAX_LINES; i++) begin
          if (6'(i) < lines) begin
            if (txe[i] && am_n[i]) tr_n[i] = 1'b1;
            if (rxp[i]) begin
              rr_n[i] = 1'b1; am_n[i] = 1'b1;
            end
            if (an_n[i] && !conn[i]) begin
              an_n[i] = 1'b0;
              am_n = am_n | bit64(7'(i) + {1'b0, modem_base});
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Scanner: rotate the map so the current position is bit 0, then find
  // the lowest set bit.
  logic [63:0] rot;
  logic [5:0]  hit_ofs, hit_pos;
  logic        hit;
  always_comb begin
    rot = (attention_map >> scan_position) | (attention_map << (7'd64 - {1'b0, scan_position}));
    hit = |attention_map;
    hit_ofs = '0;
    for (int i = 63; i >= 0; i--) begin
      if (rot[i]) hit_ofs = 6'(i);
    end
    hit_pos = scan_position + hit_ofs;
  end

  logic [5:0] sb_s;
  logic       irq_s;
  always_comb begin
    sb_s = status_bits;
    irq_s = irq_req;
    if (do_scan) begin
      sb_s[4:3] = 2'b00;
      irq_s = 1'b0;
      if (hit) begin
        if (hit_pos >= modem_base) sb_s[3] = 1'b1;
        else begin
          if (hit_pos < MaxL && receive_ready[hit_pos[$clog2(MAX_LINES)-1:0]]) sb_s[3] = 1'b1;
          if (hit_pos < MaxL && transmit_ready[hit_pos[$clog2(MAX_LINES)-1:0]]) sb_s[4] = 1'b1;
        end
        if (sb_s[2:0] != 3'd0) irq_s = 1'b1;
      end
    end else if (is_tick && hit && status_bits[2:0] != 3'd0) begin
      irq_s = 1'b1;
    end
  end

  // Clocked state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      modem_base <= 6'd32; line_count <= 6'd8;
      attention_map <= '0; scan_position <= '0; status_bits <= '0; irq_req <= 1'b0;
      transmit_ready <= '0; receive_ready <= '0; hooked <= '0;
      ringing <= '0; answered <= '0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_MODEM_BASE) modem_base <= cfg_data;
        else line_count <= cfg_data;
      end
      if (cmd.exec) begin
        attention_map <= am_n; status_bits <= sb_n; scan_position <= sp_n;
        transmit_ready <= tr_n; receive_ready <= rr_n; hooked <= oh_n;
        ringing <= rg_n; answered <= an_n;
      end
      if (cmd.scan) begin
        status_bits <= sb_s; irq_req <= irq_s;
        if (do_scan && hit) scan_position <= hit_pos;
      end
    end
  end

  // Item capture, per-step results and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_word;
    if (cmd.exec) begin
      rd <= rd_n; txv <= txv_n; txl <= txl_n; txc <= txc_n; pop <= pop_n;
      hv <= hv_n; hl <= hl_n; ha <= ha_n; do_scan <= scan_n; is_tick <= tick_n;
    end
    if (cmd.scan) begin
      out_reg.read_data <= (item.action == ACT_STATUS) ? {19'd0, sb_s[4:0]} : rd;
      out_reg.interrupt_active <= irq_s;
      out_reg.pi_channel <= sb_s[2:0];
      out_reg.tx_valid <= txv; out_reg.tx_line <= txl; out_reg.tx_char <= txc;
      out_reg.rx_pop <= pop; out_reg.hangup_valid <= hv; out_reg.hangup_line <= hl;
      out_reg.hangup_all <= ha;
    end
  end
endmodule

/* design/terminal_mux_line_scanner_unit.sv */
// Top level of the terminal multiplexer line scanner.
// Depends on tmls_pkg, tmls_ctrl and tmls_dp.
//
// Usage:
//   The input channel (in_valid, in_stall, in_word) carries one word per bus
//   access or service tick. The output channel (out_valid, out_stall,
//   out_word) returns exactly one result word for every input word. Registers
//   modem_base (index 0) and line_count (index 1) are configured through
//   cfg_wen/cfg_index/cfg_data; the user must do so while idle (unchecked).
// Sequence:
//   A word is captured, its action is applied in the next cycle, and the
//   scanner runs once the output register is free, loading it with the
//   result. A new word is accepted only after the scanner has run for the
//   last one. The 64-bit rotate and priority search of the scanner sets the
//   length of the last step.
// Reset:
//   rst clears all line state, the attention map and the scan position,
//   and sets modem_base to 32 and line_count to 8.
// Stall:
//   While out_stall holds a result, the block finishes the next word's action
//   but waits before the scan step until the output register is free.
module terminal_mux_line_scanner_unit #(
  parameter int MAX_LINES = tmls_pkg::MaxLines
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tmls_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tmls_pkg::out_word_t out_word,
  input  logic                cfg_wen,
  input  logic [0:0]          cfg_index,
  input  logic [5:0]          cfg_data
);
  import tmls_pkg::*;

  cmd_t cmd;

  tmls_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  tmls_dp #(.MAX_LINES(MAX_LINES)) u_dp (
    .clk, .rst, .cmd, .in_word, .cfg_wen, .cfg_index, .cfg_data, .out_word
  );
endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the terminal multiplexer line scanner.
// Depends on tmls_pkg and terminal_mux_line_scanner_unit; predicts every result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmls_pkg::*;

  // Scanner behavior model plus a queue of expected result words.
  class scan_scoreboard;
    bit [5:0] modem_base;
    bit [5:0] line_count;
    bit [63:0] attn;
    bit [5:0] scan_pos;
    bit [5:0] status;
    bit [31:0] tx_rdy, rx_rdy, hook, ring, answ;
    bit irq;
    out_word_t pending[$];
    int errors;
    int checked;

    function void clear();
      modem_base = 6'd32; line_count = 6'd8; attn = '0; scan_pos = '0; status = '0;
      tx_rdy = '0; rx_rdy = '0; hook = '0; ring = '0; answ = '0; irq = 1'b0;
    endfunction

    function bit [31:0] b32(int unsigned n);
      return n < 32 ? 32'd1 << n : 32'd0;
    endfunction

    function bit [63:0] b64(int unsigned n);
      return n < 64 ? 64'd1 << n : 64'd0;
    endfunction

    function void raise();
      if (status[2:0] != 0) irq = 1;
    endfunction

    // Stop at the next flagged line from the current position.
    function void rescan();
      bit [5:0] p;
      status[4:3] = 0;
      irq = 0;
      if (attn == 0) return;
      for (int i = 0; i < 64; i++) begin
        p = scan_pos + i[5:0];
        if (attn[p]) begin
          scan_pos = p;
          if (p >= modem_base) status[3] = 1;
          else begin
            if (rx_rdy & b32(p)) status[3] = 1;
            if (tx_rdy & b32(p)) status[4] = 1;
          end
          raise();
          return;
        end
      end
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      int unsigned lines, ln, off;
      bit [31:0] m;
      bit more;
      bit [24:0] wd;
      r = '0;
      wd = w.write_data;
      lines = line_count < MaxLines ? line_count : MaxLines;
      case (w.action)
        ACT_STATUS: begin
          if (status[4:3] == 0) rescan();
          r.read_data = {19'd0, status[4:0]};
        end
        ACT_CTRL: begin
          status[2:0] = wd[2:0];
          if (wd[3]) scan_pos = 0;
          if (wd[4]) status[4] = 1;
          if (wd[5]) begin
            status &= 6'd7; r.hangup_all = 1;
            tx_rdy = 0; hook = 0; rx_rdy = 0; answ = 0; ring = 0; attn = 0;
          end
          rescan();
        end
        ACT_WRITE: begin
          ln = wd[24] ? wd[23:18] : scan_pos;
          if (ln >= modem_base) begin
            if (wd[7]) attn |= b64(ln); else attn &= ~b64(ln);
            off = ln - modem_base;
            if (off < MaxLines) begin
              m = b32(off);
              if (!wd[6]) begin
                rx_rdy &= ~m; tx_rdy &= ~m; hook &= ~m;
                if ((answ & m) && (w.conn_mask & m)) begin
                  r.hangup_valid = 1; r.hangup_line = 5'(off); answ &= ~m;
                end
              end else begin
                hook |= m;
                if (ring & m) begin
                  attn |= b64(ln); ring &= ~m; answ |= m;
                end
              end
            end
          end else if (ln < lines) begin
            m = b32(ln);
            if (wd[8]) begin
              tx_rdy &= ~m; attn &= ~b64(ln);
            end else if (w.conn_mask & m) begin
              r.tx_valid = 1; r.tx_line = 5'(ln); r.tx_char = wd[7:0];
              if (w.tx_empty_mask & m) tx_rdy |= m; else tx_rdy &= ~m;
              attn |= b64(ln);
            end
          end
          rescan();
        end
        ACT_READ: begin
          ln = scan_pos;
          r.read_data = 24'(ln << 18);
          if (ln >= modem_base) begin
            attn &= ~b64(ln);
            off = ln - modem_base;
            if (off < MaxLines) begin
              m = b32(off);
              if (hook & m) r.read_data |= 24'o500;
              if ((answ & m) && (w.conn_mask & m)) r.read_data |= 24'o404;
              if (ring & m) r.read_data |= 24'o402;
            end
          end else if (ln < lines) begin
            m = b32(ln);
            more = 0;
            if (w.rx_pending_mask & m) begin
              r.rx_pop = 1;
              r.read_data |= 24'o400 | (w.rx_break ? 24'd0 : {16'd0, w.rx_char});
              more = w.rx_more;
            end
            if (more) begin
              rx_rdy |= m; attn |= b64(ln);
            end else begin
              rx_rdy &= ~m; attn &= ~b64(ln);
            end
          end
          rescan();
        end
        ACT_TICK: begin
          if (w.connect_valid && w.connect_line < lines) begin
            ring |= b32(w.connect_line);
            attn |= b64(w.connect_line + modem_base);
          end
          for (int i = 0; i < lines; i++) begin
            m = b32(i);
            if ((w.tx_empty_mask & m) && attn[i]) tx_rdy |= m;
            if (w.rx_pending_mask & m) begin
              rx_rdy |= m; attn |= b64(i);
            end
            if ((answ & m) && !(w.conn_mask & m)) begin
              answ &= ~m; attn |= b64(i + modem_base);
            end
          end
          if (attn != 0) raise();
        end
        default: ;
      endcase
      r.interrupt_active = irq;
      r.pi_channel = status[2:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.read_data !== e.read_data) begin
        $error("read_data exp %h got %h", e.read_data, got.read_data); errors++;
      end
      if (got.interrupt_active !== e.interrupt_active) begin
        $error("interrupt_active exp %b got %b", e.interrupt_active, got.interrupt_active);
        errors++;
      end
      if (got.pi_channel !== e.pi_channel) begin
        $error("pi_channel exp %d got %d", e.pi_channel, got.pi_channel); errors++;
      end
      if (got.tx_valid !== e.tx_valid) begin
        $error("tx_valid exp %b got %b", e.tx_valid, got.tx_valid); errors++;
      end
      if (got.tx_line !== e.tx_line) begin
        $error("tx_line exp %d got %d", e.tx_line, got.tx_line); errors++;
      end
      if (got.tx_char !== e.tx_char) begin
        $error("tx_char exp %h got %h", e.tx_char, got.tx_char); errors++;
      end
      if (got.rx_pop !== e.rx_pop) begin
        $error("rx_pop exp %b got %b", e.rx_pop, got.rx_pop); errors++;
      end
      if (got.hangup_valid !== e.hangup_valid) begin
        $error("hangup_valid exp %b got %b", e.hangup_valid, got.hangup_valid); errors++;
      end
      if (got.hangup_line !== e.hangup_line) begin
        $error("hangup_line exp %d got %d", e.hangup_line, got.hangup_line); errors++;
      end
      if (got.hangup_all !== e.hangup_all) begin
        $error("hangup_all exp %b got %b", e.hangup_all, got.hangup_all); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_word;
  logic cfg_wen = 0;
  logic [0:0] cfg_index = REG_MODEM_BASE;
  logic [5:0] cfg_data = 0;

  scan_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  longint cycle = 0;
  localparam longint CycleLimit = 400000;

  terminal_mux_line_scanner_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("terminal_mux_line_scanner_unit regression: fail");
      $finish;
    end
  end

  // Receiver: random stall and checking of accepted words.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Send one word, with a random idle gap before it. Valid stays high after
  // acceptance until the next word or an idle cycle replaces it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    sent++;
  endtask

  // Let every expected word drain, then allow for latency.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [5:0] val);
    cfg_wen <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
    if (idx == REG_MODEM_BASE) sb.modem_base = val; else sb.line_count = val;
    @(posedge clk);
  endtask

  // Random word biased toward well-formed accesses on lines in use.
  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned pick;
    w.action = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 5))
                                       : 3'($urandom_range(4));
    w.write_data = 25'($urandom);
    pick = $urandom_range(2);
    if (pick == 0) w.write_data[23:18] = 6'($urandom_range(sb.line_count));
    else if (pick == 1) w.write_data[23:18] = sb.modem_base + 6'($urandom_range(7));
    w.write_data[5] = ($urandom_range(19) == 0);
    w.connect_valid = 1'($urandom_range(1));
    w.connect_line = 5'($urandom);
    w.conn_mask = $urandom;
    w.rx_pending_mask = $urandom;
    w.tx_empty_mask = $urandom;
    w.rx_char = 8'($urandom);
    w.rx_break = ($urandom_range(7) == 0);
    w.rx_more = 1'($urandom_range(1));
    return w;
  endfunction

  initial begin
    in_word_t w;
    sb.clear();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed words: every action, field extremes and edge cases.
    w = '0;
    w.action = ACT_STATUS; send_word(w);
    w.action = ACT_CTRL; w.write_data = 25'o17; send_word(w);
    w.action = ACT_TICK; w.connect_valid = 1; w.connect_line = 3;
    w.conn_mask = '1; w.rx_pending_mask = 32'h5; w.tx_empty_mask = '1; send_word(w);
    w.action = ACT_READ; w.rx_char = 8'hff; w.rx_more = 1; send_word(w);
    w.rx_break = 1; send_word(w);
    w.action = ACT_WRITE; w.write_data = {1'b1, 6'd2, 10'd0, 8'h41}; send_word(w);
    w.write_data = {1'b1, 6'd35, 10'd0, 8'o300}; send_word(w);
    w.action = ACT_READ; send_word(w);
    w.action = ACT_WRITE; w.write_data = {1'b1, 6'd35, 10'd0, 8'o000}; send_word(w);
    w.write_data = {1'b1, 6'd63, 10'd0, 8'o200}; send_word(w);
    w.write_data = {1'b1, 6'd5, 9'd0, 9'o400}; send_word(w);
    w.write_data = {1'b1, 6'd20, 10'd0, 8'h33}; send_word(w);
    w.action = ACT_TICK; w.connect_line = 31; w.conn_mask = 0; send_word(w);
    w.action = 3'd5; send_word(w);
    w.action = 3'd7; w.write_data = '1; send_word(w);
    w.action = ACT_CTRL; w.write_data = 25'o0; send_word(w);
    w.action = ACT_TICK; w.connect_line = 0; w.rx_pending_mask = '1; send_word(w);
    w.action = ACT_STATUS; send_word(w);
    w.action = ACT_CTRL; w.write_data = 25'o67; send_word(w);
    drain();

    // Random phases across register settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      case (ph)
        0: begin write_reg(REG_MODEM_BASE, 8);  write_reg(REG_LINE_COUNT, 8);  end
        1: begin write_reg(REG_MODEM_BASE, 32); write_reg(REG_LINE_COUNT, 32); end
        2: begin write_reg(REG_MODEM_BASE, 16); write_reg(REG_LINE_COUNT, 16); end
        3: begin write_reg(REG_MODEM_BASE, 48); write_reg(REG_LINE_COUNT, 24); end
        4: begin write_reg(REG_MODEM_BASE, 63); write_reg(REG_LINE_COUNT, 63); end
        5: begin write_reg(REG_MODEM_BASE, 0);  write_reg(REG_LINE_COUNT, 0);  end
        6: begin write_reg(REG_MODEM_BASE, 24); write_reg(REG_LINE_COUNT, 8);  end
        default: begin write_reg(REG_MODEM_BASE, 40); write_reg(REG_LINE_COUNT, 32); end
      endcase
      for (int k = 0; k < 66; k++) send_word(random_word());
      drain();
    end

    $display("Sent %0d words over eight register settings and four idle patterns.", sent);
    $display("Checked %0d result words.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("terminal_mux_line_scanner_unit regression: pass");
    else
      $display("terminal_mux_line_scanner_unit regression: fail");
    $finish;
  end
endmodule
